>>> rtl/core/mdm_pkg.sv
// Shared types and constants for the mean deviation about median block.
`default_nettype none

package mdm_pkg;

  localparam int MAX_CLASSES  = 256;
  localparam int VALUE_BITS   = 32;
  localparam int FREQ_BITS    = 16;
  localparam int TOTAL_BITS   = 24;
  localparam int MEDIAN_BITS  = VALUE_BITS + 2;
  localparam int DEV_BITS     = VALUE_BITS + 1;
  localparam int STATUS_BITS  = 2;

  localparam int ADDR_BITS    = $clog2(MAX_CLASSES);
  localparam int COUNT_BITS   = $clog2(MAX_CLASSES + 1);
  localparam int DIFF_BITS    = VALUE_BITS + 3;
  localparam int ABS_BITS     = VALUE_BITS + 2;
  localparam int PROD_BITS    = ABS_BITS + FREQ_BITS;
  localparam int SUM_BITS     = PROD_BITS + ADDR_BITS;
  localparam int DIVISOR_BITS = TOTAL_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_ZERO     = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] class_value;
    logic [FREQ_BITS-1:0]         class_frequency;
    logic                         last_class;
  } item_t;

  typedef struct packed {
    logic signed [MEDIAN_BITS-1:0] median_value;
    logic [DEV_BITS-1:0]           avg_abs_dev;
    logic [STATUS_BITS-1:0]        status;
  } result_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [FREQ_BITS-1:0]         freq;
  } entry_t;

  typedef struct packed {
    logic signed [MEDIAN_BITS-1:0] median2;
    logic [SUM_BITS-1:0]           dev_sum;
  } eng_result_t;

endpackage

`default_nettype wire

>>> rtl/core/mdm_class_ram.sv
// Class storage: one write port, one registered read port.
`default_nettype none

module mdm_class_ram (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [mdm_pkg::ADDR_BITS-1:0] wr_addr,
  input  wire mdm_pkg::entry_t             wr_data,
  input  wire logic [mdm_pkg::ADDR_BITS-1:0] rd_addr,
  output mdm_pkg::entry_t                  rd_data
);

  mdm_pkg::entry_t mem [0:mdm_pkg::MAX_CLASSES-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/core/mdm_engine.sv
// Median search pass and weighted deviation sum pass over the class RAM.
`default_nettype none

module mdm_engine (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [mdm_pkg::COUNT_BITS-1:0] count,
  input  wire logic [mdm_pkg::TOTAL_BITS-1:0] total,
  output logic [mdm_pkg::ADDR_BITS-1:0]       rd_addr,
  input  wire mdm_pkg::entry_t                rd_data,
  output logic                                done,
  output mdm_pkg::eng_result_t                res
);

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_MED  = 2'd1;
  localparam logic [1:0] E_MID  = 2'd2;
  localparam logic [1:0] E_SUM  = 2'd3;

  logic [1:0] state;
  logic [mdm_pkg::COUNT_BITS-1:0] idx;
  logic issuing;
  logic rd_vld;
  logic v1;
  logic v2;

  logic [mdm_pkg::TOTAL_BITS-1:0] cum;
  logic [mdm_pkg::TOTAL_BITS-1:0] cum_next;
  logic [mdm_pkg::TOTAL_BITS-1:0] rank_lo;
  logic [mdm_pkg::TOTAL_BITS-1:0] rank_hi;
  logic found_lo;
  logic found_hi;
  logic signed [mdm_pkg::VALUE_BITS-1:0] v_lo;
  logic signed [mdm_pkg::VALUE_BITS-1:0] v_hi;
  logic signed [mdm_pkg::MEDIAN_BITS-1:0] median2;

  logic signed [mdm_pkg::DIFF_BITS-1:0] two_v;
  logic signed [mdm_pkg::DIFF_BITS-1:0] med_ext;
  logic signed [mdm_pkg::DIFF_BITS-1:0] diff;
  logic [mdm_pkg::DIFF_BITS-1:0] abs_full;
  logic [mdm_pkg::ABS_BITS-1:0] absd;
  logic [mdm_pkg::FREQ_BITS-1:0] f1;
  logic [mdm_pkg::PROD_BITS-1:0] prod;
  logic [mdm_pkg::SUM_BITS-1:0] acc;

  assign issuing = ((state == E_MED) || (state == E_SUM)) && (idx < count);
  assign rd_addr = idx[mdm_pkg::ADDR_BITS-1:0];

  // lower middle rank equals upper one when the total is odd
  assign rank_hi  = (total >> 1) + mdm_pkg::TOTAL_BITS'(1);
  assign rank_lo  = total[0] ? rank_hi : (total >> 1);
  assign cum_next = cum + mdm_pkg::TOTAL_BITS'(rd_data.freq);

  assign two_v   = {{(mdm_pkg::DIFF_BITS - mdm_pkg::VALUE_BITS - 1){rd_data.value[mdm_pkg::VALUE_BITS-1]}},
                    rd_data.value, 1'b0};
  assign med_ext = {{(mdm_pkg::DIFF_BITS - mdm_pkg::MEDIAN_BITS){median2[mdm_pkg::MEDIAN_BITS-1]}},
                    median2};
  assign diff     = two_v - med_ext;
  assign abs_full = diff[mdm_pkg::DIFF_BITS-1] ? (~diff + mdm_pkg::DIFF_BITS'(1)) : diff;

  assign done = (state == E_SUM) && !issuing && !rd_vld && !v1 && !v2;
  assign res.median2 = median2;
  assign res.dev_sum = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= E_IDLE;
      idx    <= '0;
      rd_vld <= 1'b0;
      v1     <= 1'b0;
      v2     <= 1'b0;
    end else begin
      rd_vld <= issuing;
      v1     <= rd_vld && (state == E_SUM);
      v2     <= v1;
      if (issuing) begin
        idx <= idx + mdm_pkg::COUNT_BITS'(1);
      end
      case (state)
        E_IDLE: begin
          if (start) begin
            idx   <= '0;
            state <= E_MED;
          end
        end
        E_MED: begin
          if (!issuing && !rd_vld) begin
            state <= E_MID;
          end
        end
        E_MID: begin
          idx   <= '0;
          state <= E_SUM;
        end
        E_SUM: begin
          if (done) begin
            state <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  // median pass datapath
  always_ff @(posedge clk) begin
    if (state == E_IDLE && start) begin
      cum      <= '0;
      found_lo <= 1'b0;
      found_hi <= 1'b0;
    end else if (state == E_MED && rd_vld) begin
      cum <= cum_next;
      if (!found_lo && (rank_lo <= cum_next)) begin
        found_lo <= 1'b1;
        v_lo     <= rd_data.value;
      end
      if (!found_hi && (rank_hi <= cum_next)) begin
        found_hi <= 1'b1;
        v_hi     <= rd_data.value;
      end
    end
    if (state == E_MID) begin
      median2 <= mdm_pkg::MEDIAN_BITS'(v_lo) + mdm_pkg::MEDIAN_BITS'(v_hi);
    end
  end

  // sum pass: abs stage, multiply stage, accumulate
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      absd <= abs_full[mdm_pkg::ABS_BITS-1:0];
      f1   <= rd_data.freq;
    end
    if (v1) begin
      prod <= mdm_pkg::PROD_BITS'(f1) * mdm_pkg::PROD_BITS'(absd);
    end
    if (state == E_MID) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + mdm_pkg::SUM_BITS'(prod);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mdm_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module mdm_divider (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [mdm_pkg::SUM_BITS-1:0]     dividend,
  input  wire logic [mdm_pkg::DIVISOR_BITS-1:0] divisor,
  output logic                                  done,
  output logic [mdm_pkg::SUM_BITS-1:0]          quotient
);

  logic busy;
  logic [mdm_pkg::DIV_CNT_BITS-1:0] cnt;
  logic [mdm_pkg::SUM_BITS-1:0] quo;
  logic [mdm_pkg::DIVISOR_BITS-1:0] rem;
  logic [mdm_pkg::DIVISOR_BITS-1:0] dvs;
  logic [mdm_pkg::DIVISOR_BITS:0] trial;
  logic [mdm_pkg::DIVISOR_BITS:0] sub;
  logic take;

  assign trial    = {rem, quo[mdm_pkg::SUM_BITS-1]};
  assign sub      = trial - {1'b0, dvs};
  assign take     = (trial >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + mdm_pkg::DIV_CNT_BITS'(1);
        if (cnt == mdm_pkg::DIV_CNT_BITS'(mdm_pkg::SUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[mdm_pkg::SUM_BITS-2:0], take};
      rem <= take ? sub[mdm_pkg::DIVISOR_BITS-1:0] : trial[mdm_pkg::DIVISOR_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mean_deviation_about_median_top.sv
// Top level: class loading, median/deviation sequencing, division and result register.
//
//   channel  | signals                     | payload
//   ---------+-----------------------------+------------------------------------------
//   item     | item_valid / item_ready     | class_value, class_frequency, last_class
//   result   | result_valid / result_ready | median_value, avg_abs_dev, status
//
// One item transaction per cycle while loading; up to capacity, each class goes into the RAM.
// After the closing transaction, with N stored classes: a median pass, a deviation pass
// (RAM read, abs, multiply, accumulate), 58 divider steps and the result register load,
// which raises result_valid; error results skip the passes and the divider.
// item_ready stays low from the closing transaction until the result register is loaded,
// which waits while an earlier result is held. Sync reset clears control, not the RAM.
`default_nettype none

module mean_deviation_about_median_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire mdm_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output mdm_pkg::result_t      result
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN  = 2'd1;
  localparam logic [1:0] T_DIV  = 2'd2;
  localparam logic [1:0] T_OUT  = 2'd3;

  logic [1:0] state;
  logic [mdm_pkg::COUNT_BITS-1:0] class_count;
  logic [mdm_pkg::TOTAL_BITS-1:0] total;
  logic overflow;

  logic accept;
  logic store_ok;
  logic [mdm_pkg::TOTAL_BITS:0] new_total;
  logic ovf_next;
  logic [mdm_pkg::TOTAL_BITS-1:0] total_next;

  logic eng_start;
  logic eng_done;
  mdm_pkg::eng_result_t eng_res;
  logic [mdm_pkg::ADDR_BITS-1:0] rd_addr;
  mdm_pkg::entry_t rd_data;
  mdm_pkg::entry_t wr_data;

  logic div_done;
  logic [mdm_pkg::SUM_BITS-1:0] quotient;

  mdm_pkg::result_t pend;
  logic out_free;

  assign item_ready = (state == T_IDLE);
  assign accept     = item_valid && item_ready;
  assign store_ok   = class_count < mdm_pkg::COUNT_BITS'(mdm_pkg::MAX_CLASSES);
  assign new_total  = {1'b0, total} + (mdm_pkg::TOTAL_BITS + 1)'(item.class_frequency);
  assign ovf_next   = overflow || !store_ok || new_total[mdm_pkg::TOTAL_BITS];
  assign total_next = new_total[mdm_pkg::TOTAL_BITS] ? total
                                                     : new_total[mdm_pkg::TOTAL_BITS-1:0];
  assign out_free   = !result_valid || result_ready;

  assign wr_data.value = item.class_value;
  assign wr_data.freq  = item.class_frequency;

  mdm_class_ram u_ram (
    .clk     (clk),
    .wr_en   (accept && store_ok),
    .wr_addr (class_count[mdm_pkg::ADDR_BITS-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mdm_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (eng_start),
    .count   (class_count),
    .total   (total),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (eng_done),
    .res     (eng_res)
  );

  mdm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (eng_done),
    .dividend (eng_res.dev_sum),
    .divisor  ({total, 1'b0}),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      class_count  <= '0;
      total        <= '0;
      overflow     <= 1'b0;
      eng_start    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      eng_start <= 1'b0;
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            if (store_ok) begin
              class_count <= class_count + mdm_pkg::COUNT_BITS'(1);
            end
            total    <= total_next;
            overflow <= ovf_next;
            if (item.last_class) begin
              if (ovf_next || (total_next == '0)) begin
                state <= T_OUT;
              end else begin
                eng_start <= 1'b1;
                state     <= T_RUN;
              end
            end
          end
        end
        T_RUN: begin
          if (eng_done) begin
            state <= T_DIV;
          end
        end
        T_DIV: begin
          if (div_done) begin
            state <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            class_count  <= '0;
            total        <= '0;
            overflow     <= 1'b0;
            state        <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // pending result and output register
  always_ff @(posedge clk) begin
    if (state == T_IDLE && accept && item.last_class) begin
      pend.median_value <= '0;
      pend.avg_abs_dev  <= '0;
      if (ovf_next) begin
        pend.status <= mdm_pkg::ST_OVERFLOW;
      end else if (total_next == '0) begin
        pend.status <= mdm_pkg::ST_ZERO;
      end else begin
        pend.status <= mdm_pkg::ST_OK;
      end
    end
    if (state == T_RUN && eng_done) begin
      pend.median_value <= eng_res.median2;
    end
    if (state == T_DIV && div_done) begin
      pend.avg_abs_dev <= quotient[mdm_pkg::DEV_BITS-1:0];
    end
    if (state == T_OUT && out_free) begin
      result <= pend;
    end
  end

  a_eng_done_in_run: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> (state == T_RUN))
    else $error("engine finished outside its run phase");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == T_DIV))
    else $error("divider finished outside its phase");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    class_count <= mdm_pkg::COUNT_BITS'(mdm_pkg::MAX_CLASSES))
    else $error("class count beyond capacity");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != mdm_pkg::ST_OK)) |->
      ((result.median_value == '0) && (result.avg_abs_dev == '0)))
    else $error("error result carries nonzero values");

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the weighted mean deviation about median block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 150;
  localparam int QUIET_ITEMS  = 40;
  localparam int LONG_HOLD    = 1500;
  localparam int DRAIN_CYCLES = 2 * mdm_pkg::MAX_CLASSES + 100;
  localparam int LIMIT_NS     = 8_000_000;

  typedef enum {SPREAD_FULL, SPREAD_NARROW, SPREAD_COARSE} spread_t;
  typedef enum {WEIGHT_LIGHT, WEIGHT_HEAVY, WEIGHT_SPARSE} weight_t;

  typedef struct packed {
    mdm_pkg::item_t   stim;
    logic             pinned;
    mdm_pkg::result_t want;
  } stim_row_t;

  localparam mdm_pkg::result_t NO_STATS = '0;

  // Rows with pinned=1 carry a hand-computed result; the rest go through the predictor.
  localparam stim_row_t DIRECTED_ROWS [24] = '{
    // single class straight out of reset: 1.0 with weight 1
    '{'{32'sh0001_0000, 16'd1, 1'b1}, 1'b1, '{34'sh0_0002_0000, 33'h0, mdm_pkg::ST_OK}},
    // zero total, single class
    '{'{32'sh7FFF_FFFF, 16'd0, 1'b1}, 1'b1, '{34'sh0, 33'h0, mdm_pkg::ST_ZERO}},
    // zero total over two classes
    '{'{32'sh0003_0000, 16'd0, 1'b0}, 1'b0, NO_STATS},
    '{'{32'sh0004_0000, 16'd0, 1'b1}, 1'b1, '{34'sh0, 33'h0, mdm_pkg::ST_ZERO}},
    // extreme values, full weight
    '{'{32'sh7FFF_FFFF, 16'hFFFF, 1'b1}, 1'b1, '{34'sh0_FFFF_FFFE, 33'h0, mdm_pkg::ST_OK}},
    '{'{32'sh8000_0000, 16'hFFFF, 1'b1}, 1'b1, '{34'sh3_0000_0000, 33'h0, mdm_pkg::ST_OK}},
    // both extremes, even total: median averages them
    '{'{32'sh8000_0000, 16'd1, 1'b0}, 1'b0, NO_STATS},
    '{'{32'sh7FFF_FFFF, 16'd1, 1'b1}, 1'b1,
      '{34'sh3_FFFF_FFFF, 33'h0_7FFF_FFFF, mdm_pkg::ST_OK}},
    '{'{32'sh8000_0000, 16'hFFFF, 1'b0}, 1'b0, NO_STATS},
    '{'{32'sh7FFF_FFFF, 16'hFFFF, 1'b1}, 1'b0, NO_STATS},
    // 1..4, even total
    '{'{32'sh0001_0000, 16'd1, 1'b0}, 1'b0, NO_STATS},
    '{'{32'sh0002_0000, 16'd1, 1'b0}, 1'b0, NO_STATS},
    '{'{32'sh0003_0000, 16'd1, 1'b0}, 1'b0, NO_STATS},
    '{'{32'sh0004_0000, 16'd1, 1'b1}, 1'b1,
      '{34'sh0_0005_0000, 33'h0_0001_0000, mdm_pkg::ST_OK}},
    // out of order classes
    '{'{32'sh0003_0000, 16'd2, 1'b0}, 1'b0, NO_STATS},
    '{'{32'shFFFE_8000, 16'd1, 1'b0}, 1'b0, NO_STATS},
    '{'{32'sh0000_8000, 16'd4, 1'b1}, 1'b0, NO_STATS},
    // zero-weight classes mixed in
    '{'{32'sh0001_0000, 16'd0, 1'b0}, 1'b0, NO_STATS},
    '{'{32'sh0002_0000, 16'd3, 1'b0}, 1'b0, NO_STATS},
    '{'{32'sh0004_0000, 16'd0, 1'b0}, 1'b0, NO_STATS},
    '{'{32'sh0008_0000, 16'd1, 1'b1}, 1'b0, NO_STATS},
    // alternating bit patterns
    '{'{32'sh5555_AAAA, 16'hFFFF, 1'b0}, 1'b0, NO_STATS},
    '{'{32'shAAAA_5555, 16'h8000, 1'b0}, 1'b0, NO_STATS},
    '{'{32'sh0000_FFFF, 16'h0001, 1'b1}, 1'b0, NO_STATS}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  mdm_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  mdm_pkg::result_t result;

  // predictor state for the set being loaded
  logic signed [mdm_pkg::VALUE_BITS-1:0] set_values[$];
  logic [mdm_pkg::FREQ_BITS-1:0]         set_freqs[$];
  logic [mdm_pkg::TOTAL_BITS-1:0]        set_total = '0;
  bit                                    set_overflow = 1'b0;

  mdm_pkg::result_t awaited_stats[$];
  mdm_pkg::item_t   set_items[$];
  int unsigned      items_accepted = 0;
  int unsigned      sets_closed = 0;
  int unsigned      mismatches = 0;
  bit               quiet = 1'b0;
  bit               hold_asked = 1'b0;

  mean_deviation_about_median_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // value of the first class whose running weight reaches the given rank
  function automatic logic signed [mdm_pkg::VALUE_BITS-1:0] value_at_rank(
      input int unsigned rank);
    int unsigned running;
    running = 0;
    foreach (set_values[i]) begin
      running += set_freqs[i];
      if (rank <= running) return set_values[i];
    end
    return set_values[set_values.size() - 1];
  endfunction

  function automatic mdm_pkg::result_t settle_set();
    mdm_pkg::result_t    stats;
    longint              mid2;
    longint              diff;
    longint unsigned     gap;
    longint unsigned     dev_sum;
    int unsigned         half;
    stats = '0;
    if (set_overflow) begin
      stats.status = mdm_pkg::ST_OVERFLOW;
    end else if (set_total == 0) begin
      stats.status = mdm_pkg::ST_ZERO;
    end else begin
      if (set_total[0] == 1'b0) begin
        half = set_total / 2;
        mid2 = longint'(value_at_rank(half)) + longint'(value_at_rank(half + 1));
      end else begin
        mid2 = 2 * longint'(value_at_rank((set_total + 1) / 2));
      end
      dev_sum = 0;
      foreach (set_values[i]) begin
        diff = 2 * longint'(set_values[i]) - mid2;
        gap = (diff < 0) ? longint'(-diff) : longint'(diff);
        dev_sum += gap * set_freqs[i];
      end
      stats.median_value = mid2[mdm_pkg::MEDIAN_BITS-1:0];
      stats.avg_abs_dev  = mdm_pkg::DEV_BITS'(dev_sum / (2 * longint'(set_total)));
      stats.status       = mdm_pkg::ST_OK;
    end
    set_values   = {};
    set_freqs    = {};
    set_total    = '0;
    set_overflow = 1'b0;
    return stats;
  endfunction

  // absorbs one class; returns 1 with the set's statistics when the class closes it
  function automatic bit fold_class(input mdm_pkg::item_t cls,
                                    output mdm_pkg::result_t stats);
    logic [mdm_pkg::TOTAL_BITS:0] grown;
    stats = '0;
    if (set_values.size() < mdm_pkg::MAX_CLASSES) begin
      set_values.push_back(cls.class_value);
      set_freqs.push_back(cls.class_frequency);
    end else begin
      set_overflow = 1'b1;
    end
    grown = set_total + cls.class_frequency;
    if (grown[mdm_pkg::TOTAL_BITS]) set_overflow = 1'b1;
    else set_total = grown[mdm_pkg::TOTAL_BITS-1:0];
    if (!cls.last_class) return 1'b0;
    stats = settle_set();
    return 1'b1;
  endfunction

  function automatic void draw_set(input int unsigned count, input bit ordered,
                                   input spread_t spread, input weight_t weight);
    int             vals[$];
    mdm_pkg::item_t cls;
    vals = {};
    cls  = '0;
    repeat (count) begin
      case (spread)
        SPREAD_FULL:   vals.push_back(int'($urandom()));
        SPREAD_NARROW: vals.push_back(int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
        default:       vals.push_back((int'($urandom_range(0, 20)) - 10) * 32'sh0001_0000);
      endcase
    end
    if (ordered) vals.sort();
    set_items = {};
    foreach (vals[i]) begin
      cls.class_value = vals[i];
      case (weight)
        WEIGHT_LIGHT: cls.class_frequency = mdm_pkg::FREQ_BITS'($urandom_range(0, 9));
        WEIGHT_HEAVY: cls.class_frequency = mdm_pkg::FREQ_BITS'($urandom());
        default: cls.class_frequency = ($urandom_range(0, 3) == 0) ?
                                       mdm_pkg::FREQ_BITS'($urandom_range(1, 3)) : '0;
      endcase
      cls.last_class = (i == vals.size() - 1);
      set_items.push_back(cls);
    end
  endfunction

  task automatic offer_class(input mdm_pkg::item_t cls, input bit pinned,
                             input mdm_pkg::result_t pinned_stats);
    mdm_pkg::result_t predicted;
    int unsigned      gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= cls;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    items_accepted++;
    if (fold_class(cls, predicted)) begin
      sets_closed++;
      awaited_stats.push_back(pinned ? pinned_stats : predicted);
    end
  endtask

  task automatic send_set();
    foreach (set_items[i]) offer_class(set_items[i], 1'b0, NO_STATS);
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (awaited_stats.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // result side: random stalls, one long hold on request, steady ready when quiet
  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (hold_asked) begin
        hold_asked = 1'b0;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    mdm_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (awaited_stats.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h", result));
      end else begin
        want = awaited_stats.pop_front();
        if (result.median_value !== want.median_value)
          flag_mismatch($sformatf("median_value %h, want %h",
                                  result.median_value, want.median_value));
        if (result.avg_abs_dev !== want.avg_abs_dev)
          flag_mismatch($sformatf("avg_abs_dev %h, want %h",
                                  result.avg_abs_dev, want.avg_abs_dev));
        if (result.status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", result.status, want.status));
      end
    end
  end

  initial begin : stimulus
    int unsigned random_start;
    int unsigned count;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i])
      offer_class(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);

    // capacity edge: a full set, then one class too many
    draw_set(mdm_pkg::MAX_CLASSES, 1'b1, SPREAD_FULL, WEIGHT_HEAVY);
    send_set();
    draw_set(mdm_pkg::MAX_CLASSES + 1, 1'b1, SPREAD_NARROW, WEIGHT_LIGHT);
    send_set();

    // long result stall while sets keep coming: the block backs up into its input
    hold_asked = 1'b1;
    repeat (4) begin
      draw_set(3, 1'b1, SPREAD_NARROW, WEIGHT_LIGHT);
      send_set();
    end
    drain_results();

    random_start = items_accepted;
    while (items_accepted - random_start < RANDOM_ITEMS) begin
      quiet = (items_accepted - random_start >= RANDOM_ITEMS - QUIET_ITEMS);
      count = $urandom_range(1, 12);
      draw_set(count, $urandom_range(0, 7) != 0,
               spread_t'($urandom_range(0, 2)), weight_t'($urandom_range(0, 2)));
      send_set();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** mean_deviation_about_median_top: PASSED **");
    end else begin
      $display("** mean_deviation_about_median_top: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("timeout with %0d results outstanding", awaited_stats.size());
    $display("** mean_deviation_about_median_top: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/mdm_pkg.sv
rtl/core/mdm_class_ram.sv
rtl/core/mdm_engine.sv
rtl/core/mdm_divider.sv
rtl/core/mean_deviation_about_median_top.sv
sim/testbench.sv
